// File: rtl/core/cwo_pkg.sv
package cwo_pkg;

   // default sizes
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int WEIGHT_BITS_DEF = 8;

   // fixed field widths
   localparam int ADDR_MAX_W = 10;
   localparam int SEQ_W      = 18;
   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 15;
   localparam int START_W    = 10;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // start value limits and reset value
   localparam logic [START_W-1:0] START_MIN   = 10'd2;
   localparam logic [START_W-1:0] START_MAX   = 10'd1000;
   localparam logic [START_W-1:0] START_RESET = 10'd42;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_START  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INTERP = 2'd1;

   // queue between front and back
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = 2;
   localparam int FQ_CNT_W = 3;

   // q1.15 unity
   localparam logic [SAMPLE_W-1:0] ONE_Q15 = 16'd32768;

   // table write beat from the builder
   typedef struct packed {
      logic                  en;
      logic [ADDR_MAX_W-1:0] addr;
      logic [SAMPLE_W-1:0]   data;
   } tbl_wr_type;

   // shift and subtract quotient; elaboration only
   function automatic longint unsigned quot_u64(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = (r << 1) | ((num >> i) & 64'd1);
         if (r >= den) begin
            r = r - den;
            q = q | (64'd1 << i);
         end
      end
      return q;
   endfunction

   // (1 - cos(pi*k/2^bits))/2 in q1.15, for k up to half; elaboration only
   function automatic logic [15:0] half_weight(int unsigned k, int unsigned bits);
      longint unsigned theta;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          d;
      theta = (64'd3373259426 * longint'(k)) >> bits;
      x2    = (theta * theta) >> 30;
      term  = 64'd1073741824;
      sum   = 64'sd1073741824;
      for (int n = 1; n <= 10; n++) begin
         term = quot_u64((term * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
         if (n[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum > 64'sd1073741824) begin
         sum = 64'sd1073741824;
      end
      d = 64'sd1073741824 - sum;
      if (d < 0) begin
         d = 0;
      end
      return 16'((d + 32768) >>> 16);
   endfunction

endpackage

// File: rtl/core/cwo_front.sv
module cwo_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,   // [15:0] position
   input  logic                      build_busy,
   output logic                      q_valid,
   output logic [cwo_pkg::MAG_W-1:0] q_mag,
   input  logic                      q_pop
);
   import cwo_pkg::*;

   logic [MAG_W-1:0]    fq_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0] wr_ptr_ff;
   logic [FQ_PTR_W-1:0] rd_ptr_ff;
   logic [FQ_CNT_W-1:0] count_ff;
   logic [FQ_CNT_W-1:0] count_in;
   logic                push;
   logic [15:0]         neg;
   logic [MAG_W-1:0]    mag;

   // magnitude, most negative saturates
   always_comb begin
      neg = 16'(~req_tdata + 16'd1);
      if (!req_tdata[15]) begin
         mag = req_tdata[MAG_W-1:0];
      end else if (neg[15]) begin
         mag = {MAG_W{1'b1}};
      end else begin
         mag = neg[MAG_W-1:0];
      end
   end

   assign req_tready = (count_ff != FQ_CNT_W'(FQ_DEPTH)) && !build_busy;
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != '0;
   assign q_mag      = fq_ff[rd_ptr_ff];

   // queue occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fq_ff[wr_ptr_ff] <= mag;
      end
   end

endmodule

// File: rtl/core/cwo_build.sv
module cwo_build #(
   parameter int TABLE_DEPTH = cwo_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cwo_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [cwo_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                  build_busy,
   output logic                                  interp_en,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]      table_len,
   output cwo_pkg::tbl_wr_type                   tbl_wr
);
   import cwo_pkg::*;

   localparam int IDXW = $clog2(TABLE_DEPTH);
   localparam int LENW = $clog2(TABLE_DEPTH + 1);
   localparam int NW   = SEQ_W + MAG_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GEN  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_WR   = 3'd5;

   logic [SEQ_W-1:0] raw_mem [TABLE_DEPTH];

   logic [2:0]       state_ff,  state_in;
   logic [SEQ_W-1:0] val_ff,    val_in;
   logic [SEQ_W-1:0] max_ff,    max_in;
   logic [LENW-1:0]  cnt_ff,    cnt_in;
   logic [LENW-1:0]  len_ff,    len_in;
   logic [LENW-1:0]  idx_ff,    idx_in;
   logic [SEQ_W-1:0] rem_ff,    rem_in;
   logic [15:0]      num_ff,    num_in;
   logic [15:0]      quo_ff,    quo_in;
   logic [3:0]       it_ff,     it_in;
   logic             interp_ff, interp_in;
   logic [SEQ_W-1:0] raw_rd_ff;

   logic [START_W-1:0] start_clamp;
   logic [SEQ_W-1:0]   val_next;
   logic [NW-1:0]      nsum;
   logic [SEQ_W:0]     trial;
   logic               ge;
   logic               start_wr;

   assign csr_ready  = 1'b1;
   assign build_busy = state_ff != S_IDLE;
   assign interp_en  = interp_ff;
   assign table_len  = len_ff;
   assign start_wr   = csr_valid && (csr_addr == REG_START);

   // clamp the written start value
   always_comb begin
      start_clamp = csr_wdata[START_W-1:0];
      if (start_clamp < START_MIN) begin
         start_clamp = START_MIN;
      end else if (start_clamp > START_MAX) begin
         start_clamp = START_MAX;
      end
   end

   // next collatz value
   assign val_next = val_ff[0] ? SEQ_W'((val_ff << 1) + val_ff + 1'b1) : (val_ff >> 1);

   // scaled dividend and one restoring step
   assign nsum  = {raw_rd_ff, MAG_W'(0)} + NW'(max_ff >> 1);
   assign trial = {rem_ff, num_ff[15]};
   assign ge    = trial >= {1'b0, max_ff};

   // sequencer
   always_comb begin
      state_in  = state_ff;
      val_in    = val_ff;
      max_in    = max_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      it_in     = it_ff;
      interp_in = interp_ff;
      tbl_wr    = '0;
      case (state_ff)
         S_GEN: begin
            cnt_in = cnt_ff + 1'b1;
            if (val_ff == SEQ_W'(1) || cnt_ff == LENW'(TABLE_DEPTH - 1)) begin
               len_in   = cnt_ff + 1'b1;
               idx_in   = '0;
               state_in = S_RD;
            end else begin
               val_in = val_next;
               if (val_next > max_ff) begin
                  max_in = val_next;
               end
            end
         end
         S_RD: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            rem_in   = SEQ_W'(nsum[NW-1:16]);
            num_in   = nsum[15:0];
            quo_in   = '0;
            it_in    = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? SEQ_W'(trial - {1'b0, max_ff}) : trial[SEQ_W-1:0];
            quo_in = {quo_ff[14:0], ge};
            num_in = num_ff << 1;
            it_in  = it_ff + 1'b1;
            if (it_ff == 4'd15) begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = ADDR_MAX_W'(idx_ff);
            tbl_wr.data = quo_ff;
            idx_in      = idx_ff + 1'b1;
            state_in    = (idx_ff + 1'b1 == len_ff) ? S_IDLE : S_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // register writes
      if (csr_valid && csr_addr == REG_INTERP) begin
         interp_in = csr_wdata[0];
      end
      if (start_wr) begin
         val_in   = SEQ_W'(start_clamp);
         max_in   = SEQ_W'(start_clamp);
         cnt_in   = '0;
         state_in = S_GEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_GEN;
         val_ff    <= SEQ_W'(START_RESET);
         max_ff    <= SEQ_W'(START_RESET);
         cnt_ff    <= '0;
         interp_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         val_ff    <= val_in;
         max_ff    <= max_in;
         cnt_ff    <= cnt_in;
         interp_ff <= interp_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      idx_ff <= idx_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      it_ff  <= it_in;
   end

   // raw sequence store
   always_ff @(posedge clock) begin
      if (state_ff == S_GEN) begin
         raw_mem[cnt_ff[IDXW-1:0]] <= val_ff;
      end
      raw_rd_ff <= raw_mem[idx_ff[IDXW-1:0]];
   end

endmodule

// File: rtl/core/cwo_back.sv
module cwo_back #(
   parameter int TABLE_DEPTH       = cwo_pkg::TABLE_DEPTH_DEF,
   parameter int WEIGHT_TABLE_BITS = cwo_pkg::WEIGHT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  logic [cwo_pkg::MAG_W-1:0]        q_mag,
   output logic                             q_pop,
   input  logic                             interp_en,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] table_len,
   input  cwo_pkg::tbl_wr_type              tbl_wr,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata   // [15:0] level
);
   import cwo_pkg::*;

   localparam int IDXW   = $clog2(TABLE_DEPTH);
   localparam int LENW   = $clog2(TABLE_DEPTH + 1);
   localparam int PW     = MAG_W + LENW;
   localparam int WCOUNT = 1 << WEIGHT_TABLE_BITS;

   typedef logic [15:0] wgt_arr_type [WCOUNT];

   function automatic wgt_arr_type build_wgt();
      wgt_arr_type t;
      for (int k = 0; k < WCOUNT; k++) begin
         if (2 * k <= WCOUNT) begin
            t[k] = half_weight(k, WEIGHT_TABLE_BITS);
         end else begin
            t[k] = 16'(32'd32768 - 32'(half_weight(WCOUNT - k, WEIGHT_TABLE_BITS)));
         end
      end
      return t;
   endfunction

   localparam wgt_arr_type WGT = build_wgt();

   logic [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];

   logic                         adv;
   logic [PW-1:0]                prod;
   logic [LENW-1:0]              a_raw;
   logic [LENW-1:0]              b_raw;
   logic [LENW-1:0]              b_wrap;
   logic [MAG_W-1:0]             frac;

   logic                         v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDXW-1:0]              a1_ff, b1_ff;
   logic [WEIGHT_TABLE_BITS-1:0] wi1_ff;
   logic [SAMPLE_W-1:0]          ta2_ff, tb2_ff, w2_ff, ta3_ff;
   logic [31:0]                  pa3_ff, pb3_ff;
   logic [31:0]                  sum;
   logic [SAMPLE_W-1:0]          level_ff, level_in;

   // whole pipe moves unless the output beat is stuck
   assign adv   = !v4_ff || rsp_tready;
   assign q_pop = adv && q_valid;

   // index split
   always_comb begin
      prod   = PW'(q_mag) * PW'(table_len);
      a_raw  = prod[PW-1:MAG_W];
      frac   = prod[MAG_W-1:0];
      b_raw  = a_raw + LENW'(frac != '0);
      b_wrap = (b_raw == table_len) ? '0 : b_raw;
   end

   assign sum      = pa3_ff + pb3_ff + 32'd16384;
   assign level_in = interp_en ? sum[30:15] : ta3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff    <= a_raw[IDXW-1:0];
         b1_ff    <= b_wrap[IDXW-1:0];
         wi1_ff   <= frac[MAG_W-1 -: WEIGHT_TABLE_BITS];
         w2_ff    <= WGT[wi1_ff];
         pa3_ff   <= 32'(ta2_ff) * 32'(ONE_Q15 - w2_ff);
         pb3_ff   <= 32'(tb2_ff) * 32'(w2_ff);
         ta3_ff   <= ta2_ff;
         level_ff <= level_in;
      end
   end

   // wave table, one write and two registered reads
   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         wave_mem[tbl_wr.addr[IDXW-1:0]] <= tbl_wr.data;
      end
      if (adv) begin
         ta2_ff <= wave_mem[a1_ff];
         tb2_ff <= wave_mem[b1_ff];
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = level_ff;

endmodule

// File: rtl/core/collatz_wavetable_oscillator.sv
// a 4-entry queue parts intake from the index, table read, product and level registers
// throughput: one position per cycle while the output takes beats and no rebuild runs;
// reset (synchronous, active high) and every start_value write rebuild the table:
// the sequence is made, then each value is scaled by the 16-step divider and stored;
// req_tready stays low during the rebuild, csr writes are always taken
module collatz_wavetable_oscillator #(
   parameter int TABLE_DEPTH       = cwo_pkg::TABLE_DEPTH_DEF,
   parameter int WEIGHT_TABLE_BITS = cwo_pkg::WEIGHT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // [15:0] position
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [15:0] level
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cwo_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cwo_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cwo_pkg::*;

   localparam int LENW = $clog2(TABLE_DEPTH + 1);

   logic             build_busy;
   logic             interp_en;
   logic [LENW-1:0]  table_len;
   tbl_wr_type       tbl_wr;
   logic             q_valid;
   logic [MAG_W-1:0] q_mag;
   logic             q_pop;

   // intake and queue
   cwo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .build_busy (build_busy),
      .q_valid    (q_valid),
      .q_mag      (q_mag),
      .q_pop      (q_pop)
   );

   // registers and table rebuild
   cwo_build #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_build (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .build_busy (build_busy),
      .interp_en  (interp_en),
      .table_len  (table_len),
      .tbl_wr     (tbl_wr)
   );

   // lookup and interpolation pipe
   cwo_back #(
      .TABLE_DEPTH       (TABLE_DEPTH),
      .WEIGHT_TABLE_BITS (WEIGHT_TABLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_mag      (q_mag),
      .q_pop      (q_pop),
      .interp_en  (interp_en),
      .table_len  (table_len),
      .tbl_wr     (tbl_wr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/core/cwo_checker.sv
module cwo_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [15:0]                    rsp_tdata,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [cwo_pkg::CSR_ADDR_W-1:0] csr_addr
);
   import cwo_pkg::*;

   // stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // stalled result beat keeps its level
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp level changed while stalled");

   // level never exceeds unity
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= ONE_Q15)
      else $error("level above 1.0");

   // table rebuild after reset blocks intake
   a_reset_build: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("intake open during rebuild after reset");

   // start write starts a rebuild
   a_start_build: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_addr == REG_START |=> !req_tready)
      else $error("intake open during rebuild after start write");

endmodule

bind collatz_wavetable_oscillator cwo_checker u_cwo_checker (.*);
